FILE: sv/distinct_label_tracker_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef DISTINCT_LABEL_TRACKER_DEFINES_SVH
`define DISTINCT_LABEL_TRACKER_DEFINES_SVH

// Plain property, sampled on clk_i, off while rst_ni is low.
`define DLT_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: whenever ante holds, cons holds in the same cycle.
`define DLT_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/dlt_pkg.sv
package dlt_pkg;

  localparam int unsigned FIELD_W = 10;
  localparam int unsigned COUNT_W = 11;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t COUNT_ONE = count_t'(1);

  // One entry of the element table.
  typedef struct packed {
    logic   valid;
    field_t label;
  } elem_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ELEM,
    ST_DROP,
    ST_ADD,
    ST_DONE
  } state_e;

endpackage

FILE: sv/dlt_in_if.sv
interface dlt_in_if;
  logic           valid;
  logic           ready;
  dlt_pkg::field_t element_index;
  dlt_pkg::field_t label;

  modport source (output valid, element_index, label, input ready);
  modport sink   (input valid, element_index, label, output ready);
endinterface

FILE: sv/dlt_out_if.sv
interface dlt_out_if;
  logic           valid;
  logic           ready;
  dlt_pkg::count_t distinct_count;

  modport source (output valid, distinct_count, input ready);
  modport sink   (input valid, distinct_count, output ready);
endinterface

FILE: sv/distinct_label_tracker.sv
// Distinct label tracker: each input word labels one element; each yields one output word
// holding the number of distinct labels in use after it. A word whose element index is not
// below NUM_ELEMENTS or whose label is not below NUM_LABELS changes nothing and returns the
// current count. After reset the block sweeps both tables, clearing every entry, with
// item_i.ready low. A word for an unlabelled element updates only its new label's count;
// one for an element that held a label first takes one more read-modify-write of the label
// count table for the old label. The count table has one read and one write port and a
// single +/-1 unit, so the old and new label counts are updated one after the other.
// Results sit in an output register, so the next word is taken while one waits there.
`include "distinct_label_tracker_defines.svh"

module distinct_label_tracker #(
  parameter int unsigned NUM_ELEMENTS = 1024,
  parameter int unsigned NUM_LABELS   = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dlt_in_if.sink   item_i,
  dlt_out_if.source result_o
);

  // Address widths, and widened forms of the 10-bit fields so that any
  // table depth indexes by a plain part-select.
  localparam int unsigned EAW  = $clog2(NUM_ELEMENTS);
  localparam int unsigned LAW  = $clog2(NUM_LABELS);
  localparam int unsigned EXW  = (EAW > dlt_pkg::FIELD_W) ? EAW : dlt_pkg::FIELD_W;
  localparam int unsigned LXW  = (LAW > dlt_pkg::FIELD_W) ? LAW : dlt_pkg::FIELD_W;
  localparam int unsigned MAXD = (NUM_ELEMENTS > NUM_LABELS) ? NUM_ELEMENTS : NUM_LABELS;
  localparam int unsigned CLW  = $clog2(MAXD);
  localparam logic [CLW-1:0] CLR_LAST = CLW'(MAXD - 1);

  // Tables
  dlt_pkg::elem_entry_t elem_mem [NUM_ELEMENTS];
  dlt_pkg::count_t      lab_mem  [NUM_LABELS];

  dlt_pkg::state_e state_q, state_d;
  logic [CLW-1:0]  clr_q, clr_d;
  dlt_pkg::count_t total_q, total_d;
  logic            fwd_q, fwd_d;
  dlt_pkg::count_t uses_fwd_q, uses_fwd_d;
  dlt_pkg::field_t old_lbl_q, old_lbl_d;
  dlt_pkg::field_t idx_q, lbl_q;
  logic            out_valid_q;
  dlt_pkg::count_t out_count_q;

  dlt_pkg::elem_entry_t elem_rd_q;
  dlt_pkg::count_t      lab_rd_q;

  // Memory port controls
  logic                 elem_re, elem_we;
  logic [EAW-1:0]       elem_raddr, elem_waddr;
  dlt_pkg::elem_entry_t elem_wdata;
  logic                 lab_re, lab_we;
  logic [LAW-1:0]       lab_raddr, lab_waddr;
  dlt_pkg::count_t      lab_wdata;

  // Shared +/-1 unit on use counts
  logic            op_inc;
  dlt_pkg::count_t uses_in, uses_step;

  logic            accept, in_range, out_free, load_out;
  dlt_pkg::count_t out_val;

  logic [EXW-1:0] in_idx_x, idx_x;
  logic [LXW-1:0] lbl_x, old_x, rd_old_x;
  logic [LAW-1:0] new_la, old_la, rd_old_la;

  assign in_idx_x   = EXW'(item_i.element_index);
  assign idx_x      = EXW'(idx_q);
  assign lbl_x      = LXW'(lbl_q);
  assign old_x      = LXW'(old_lbl_q);
  assign rd_old_x   = LXW'(elem_rd_q.label);
  assign new_la     = lbl_x[LAW-1:0];
  assign old_la     = old_x[LAW-1:0];
  assign rd_old_la  = rd_old_x[LAW-1:0];
  assign elem_raddr = in_idx_x[EAW-1:0];

  assign accept   = item_i.valid && item_i.ready;
  assign in_range = (32'(item_i.element_index) < NUM_ELEMENTS) &&
                    (32'(item_i.label) < NUM_LABELS);
  assign out_free = !out_valid_q || result_o.ready;

  assign uses_step = uses_in + (op_inc ? dlt_pkg::COUNT_ONE : dlt_pkg::COUNT_MAX);

  // Sequencer: next state, table accesses and count updates.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    total_d    = total_q;
    fwd_d      = fwd_q;
    uses_fwd_d = uses_fwd_q;
    old_lbl_d  = old_lbl_q;
    item_i.ready = 1'b0;
    elem_re    = 1'b0;
    elem_we    = 1'b0;
    elem_waddr = idx_x[EAW-1:0];
    elem_wdata = '{valid: 1'b1, label: lbl_q};
    lab_re     = 1'b0;
    lab_raddr  = new_la;
    lab_we     = 1'b0;
    lab_waddr  = new_la;
    op_inc     = 1'b1;
    uses_in    = lab_rd_q;
    lab_wdata  = uses_step;
    load_out   = 1'b0;
    out_val    = total_q;

    unique case (state_q)
      dlt_pkg::ST_CLEAR: begin
        // Sweep both tables, one entry of each per cycle.
        elem_we    = 32'(clr_q) < NUM_ELEMENTS;
        elem_waddr = clr_q[EAW-1:0];
        elem_wdata = '0;
        lab_we     = 32'(clr_q) < NUM_LABELS;
        lab_waddr  = clr_q[LAW-1:0];
        lab_wdata  = '0;
        clr_d      = clr_q + CLW'(1);
        if (clr_q == CLR_LAST) begin
          state_d = dlt_pkg::ST_IDLE;
        end
      end
      dlt_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid) begin
          elem_re = 1'b1;
          state_d = in_range ? dlt_pkg::ST_ELEM : dlt_pkg::ST_DONE;
        end
      end
      dlt_pkg::ST_ELEM: begin
        // Write the new entry; fetch the count of the old label, else the new one.
        elem_we   = 1'b1;
        old_lbl_d = elem_rd_q.label;
        fwd_d     = 1'b0;
        lab_re    = 1'b1;
        if (elem_rd_q.valid) begin
          lab_raddr = rd_old_la;
          state_d   = dlt_pkg::ST_DROP;
        end else begin
          state_d   = dlt_pkg::ST_ADD;
        end
      end
      dlt_pkg::ST_DROP: begin
        op_inc = 1'b0;
        if (lab_rd_q != '0) begin
          lab_we    = 1'b1;
          lab_waddr = old_la;
          if (lab_rd_q == dlt_pkg::COUNT_ONE && total_q != '0) begin
            total_d = total_q - dlt_pkg::COUNT_ONE;
          end
        end
        // Same label again: the read below sees the count before this write.
        fwd_d      = (old_lbl_q == lbl_q);
        uses_fwd_d = (lab_rd_q != '0) ? uses_step : lab_rd_q;
        lab_re     = 1'b1;
        state_d    = dlt_pkg::ST_ADD;
      end
      dlt_pkg::ST_ADD: begin
        uses_in = fwd_q ? uses_fwd_q : lab_rd_q;
        if (uses_in == '0 && total_q != dlt_pkg::COUNT_MAX) begin
          total_d = total_q + dlt_pkg::COUNT_ONE;
        end
        lab_we  = (uses_in != dlt_pkg::COUNT_MAX);
        out_val = total_d;
        if (out_free) begin
          load_out = 1'b1;
          state_d  = dlt_pkg::ST_IDLE;
        end else begin
          state_d  = dlt_pkg::ST_DONE;
        end
      end
      dlt_pkg::ST_DONE: begin
        // Hold until the output register frees up.
        if (out_free) begin
          load_out = 1'b1;
          state_d  = dlt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dlt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlt_pkg::ST_CLEAR;
      clr_q       <= '0;
      total_q     <= '0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      fwd_q   <= fwd_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= item_i.element_index;
      lbl_q <= item_i.label;
    end
    old_lbl_q  <= old_lbl_d;
    uses_fwd_q <= uses_fwd_d;
    if (load_out) begin
      out_count_q <= out_val;
    end
  end

  // Element table: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (elem_we) begin
      elem_mem[elem_waddr] <= elem_wdata;
    end
    if (elem_re) begin
      elem_rd_q <= elem_mem[elem_raddr];
    end
  end

  // Label use-count table: one write, one registered read.
  always_ff @(posedge clk_i) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= lab_wdata;
    end
    if (lab_re) begin
      lab_rd_q <= lab_mem[lab_raddr];
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.distinct_count = out_count_q;

  `DLT_ASSERT(a_total_bound, 32'(total_q) <= NUM_LABELS, "distinct total above label count")
  `DLT_ASSERT_IMPL(a_fwd_after_drop, state_q == dlt_pkg::ST_ADD && fwd_q,
    $past(state_q) == dlt_pkg::ST_DROP, "forwarded count without a drop step")
  `DLT_ASSERT_IMPL(a_total_moves, total_q != $past(total_q),
    $past(state_q) == dlt_pkg::ST_DROP || $past(state_q) == dlt_pkg::ST_ADD,
    "distinct total changed outside a count update")
  `DLT_ASSERT_IMPL(a_result_source, out_valid_q && !$past(out_valid_q),
    $past(state_q) == dlt_pkg::ST_ADD || $past(state_q) == dlt_pkg::ST_DONE,
    "result word raised outside a finishing step")

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

  // Table sizes of the block under test; the predictor follows the same values.
  localparam int unsigned NUM_ELEMENTS = 1024;
  localparam int unsigned NUM_LABELS   = 1024;

  // Limit of the run in clock cycles. It must cover the clearing sweep after reset
  // and, for each word, its time in the block, a random sender gap and a long
  // receiver stall. This limit is several times the slowest correct run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 12;

  // Tracks which element holds which label, how many elements use each label and
  // how many labels are in use. It also keeps the counts still owed by the block.
  class distinct_scoreboard;
    dlt_pkg::field_t held_label [NUM_ELEMENTS];
    bit              is_held    [NUM_ELEMENTS];
    dlt_pkg::count_t uses       [NUM_LABELS];
    dlt_pkg::count_t in_use;
    dlt_pkg::count_t owed_counts[$];
    int unsigned     checked;
    int unsigned     errors;
    dlt_pkg::count_t peak;

    function new();
      foreach (held_label[i]) begin
        held_label[i] = '0;
        is_held[i]    = 1'b0;
      end
      foreach (uses[i]) uses[i] = '0;
      in_use  = '0;
      checked = 0;
      errors  = 0;
      peak    = '0;
    endfunction

    function void note_word(dlt_pkg::field_t idx, dlt_pkg::field_t lbl);
      dlt_pkg::field_t old_lbl;
      if (idx < NUM_ELEMENTS && lbl < NUM_LABELS) begin
        if (is_held[idx]) begin
          old_lbl = held_label[idx];
          if (uses[old_lbl] != '0) begin
            uses[old_lbl] = uses[old_lbl] - dlt_pkg::COUNT_ONE;
            if (uses[old_lbl] == '0 && in_use != '0) in_use = in_use - dlt_pkg::COUNT_ONE;
          end
        end
        is_held[idx]    = 1'b1;
        held_label[idx] = lbl;
        if (uses[lbl] == '0 && in_use != dlt_pkg::COUNT_MAX) begin
          in_use = in_use + dlt_pkg::COUNT_ONE;
        end
        if (uses[lbl] != dlt_pkg::COUNT_MAX) uses[lbl] = uses[lbl] + dlt_pkg::COUNT_ONE;
      end
      if (in_use > peak) peak = in_use;
      owed_counts.push_back(in_use);
    endfunction

    function void check_word(dlt_pkg::count_t got);
      dlt_pkg::count_t want;
      if (owed_counts.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, actual %0d", $time, got);
        errors++;
      end else begin
        want = owed_counts.pop_front();
        checked++;
        if (got !== want) begin
          $display("%0t: distinct_count mismatch: expected %0d, actual %0d",
                   $time, want, got);
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return owed_counts.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  dlt_in_if  in_bus ();
  dlt_out_if out_bus ();

  distinct_label_tracker #(
    .NUM_ELEMENTS(NUM_ELEMENTS),
    .NUM_LABELS  (NUM_LABELS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_bus),
    .result_o(out_bus)
  );

  distinct_scoreboard sb = new();

  // Idle mix of the current phase, in percent: sender gaps and receiver stalls.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned words_sent = 0;
  int unsigned cycles     = 0;

  // Clock: 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: abandon the run once the cycle limit is passed.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: change ready on the falling edge only, as the stall mix of the phase says.
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Check every count that the block hands over, at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) sb.check_word(out_bus.distinct_count);
  end

  // Offer one word, starting just after a falling edge. Hold it until the block takes
  // it, then note it in the scoreboard. Leave valid high afterwards, so that a word
  // sent straight after this one follows with no gap.
  task automatic send_word(input dlt_pkg::field_t idx, input dlt_pkg::field_t lbl);
    int unsigned gap;
    if ($urandom_range(99) < gap_pct) begin
      gap = $urandom_range(6, 1);
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid         = 1'b1;
    in_bus.element_index = idx;
    in_bus.label         = lbl;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_word(idx, lbl);
    words_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned     sel;
    int unsigned     phase;
    dlt_pkg::field_t key;
    dlt_pkg::field_t idx;
    dlt_pkg::field_t lbl;

    in_bus.valid         = 1'b0;
    in_bus.element_index = '0;
    in_bus.label         = '0;
    rst_ni               = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed words. The block may still be clearing its tables; send_word waits
    // for ready, so the first word simply waits out the sweep.
    send_word(10'd0,     10'd0);      // first label: count rises from zero
    send_word(10'd0,     10'd0);      // relabel with the same label: count unchanged
    send_word(10'd1023,  10'd1023);   // top element, top label
    send_word(10'd0,     10'd1023);   // old label loses its only user and drops out
    send_word(10'd1,     10'd0);
    send_word(10'd2,     10'd0);      // second user of a label: no new distinct label
    send_word(10'd1,     10'd5);      // label 0 still held by element 2
    send_word(10'd2,     10'd5);      // label 0 now unused
    send_word(10'h155,   10'h2AA);    // alternating bit patterns in both fields
    send_word(10'h2AA,   10'h155);
    send_word(10'h155,   10'h155);
    send_word(10'h2AA,   10'h155);    // two elements move onto one label
    send_word(10'd1023,  10'd1023);   // same label on a held element
    send_word(10'd1023,  10'd0);
    send_word(10'd512,   10'd512);
    send_word(10'd511,   10'd511);
    send_word(10'd512,   10'd511);
    send_word(10'd511,   10'd1);
    send_word(10'd0,     10'd1);
    send_word(10'd3,     10'd1023);

    // Sweep every element onto a distinct label, so that the count climbs all the way
    // to the number of labels and the top bit of the result is exercised.
    key = dlt_pkg::field_t'($urandom_range(1023));
    for (int unsigned i = 0; i < NUM_ELEMENTS; i++) begin
      send_word(dlt_pkg::field_t'(i), dlt_pkg::field_t'(i) ^ key);
    end

    // Random words in four idle mixes. Most land on a small group of labels, many also on
    // a small group of elements, so labels keep losing their last user and coming back.
    // The rest are spread over the whole range, so every bit of both fields toggles.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      repeat (200) begin
        sel = $urandom_range(99);
        if (sel < 40) begin
          idx = dlt_pkg::field_t'($urandom_range(31));
          lbl = dlt_pkg::field_t'($urandom_range(7));
        end else if (sel < 70) begin
          idx = dlt_pkg::field_t'($urandom_range(1023));
          lbl = dlt_pkg::field_t'($urandom_range(15));
        end else begin
          idx = dlt_pkg::field_t'($urandom_range(1023));
          lbl = dlt_pkg::field_t'($urandom_range(1023));
        end
        send_word(idx, lbl);
      end
    end

    // Drop valid, stop stalling and drain the remaining counts.
    in_bus.valid = 1'b0;
    stall_pct    = 0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d label words over four idle mixes, including a full sweep of elements;",
             words_sent);
    $display("checked %0d counts, peak distinct count %0d, %0d errors.",
             sb.checked, sb.peak, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/dlt_pkg.sv
sv/dlt_in_if.sv
sv/dlt_out_if.sv
sv/distinct_label_tracker.sv
bench/tb.sv
